// File: hdl/multi_channel_heartbeat_monitor_macros.svh
// assertion macros for the heartbeat monitor
// expects clk and rst in the scope of each use
`ifndef MULTI_CHANNEL_HEARTBEAT_MONITOR_MACROS_SVH
`define MULTI_CHANNEL_HEARTBEAT_MONITOR_MACROS_SVH

// same-cycle implication
`define MCHB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heartbeat monitor: same-cycle check failed");

// next-cycle implication
`define MCHB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heartbeat monitor: next-cycle check failed");

`endif

// File: hdl/mchb_pkg.sv
// shared types, constants and register map of the heartbeat monitor
// no dependencies
package mchb_pkg;

  localparam int NUM_CHANNELS     = 8;
  localparam int SELF_CHANNEL     = 5;
  localparam int CH_W             = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TICK_W           = 32;
  localparam int MV_W             = 16;
  localparam int CFG_W            = 16;
  localparam int NUM_REGS         = 8;
  localparam int REG_IDX_W        = 3;
  localparam int MASK_W           = 8;
  localparam int NUM_OWN_TIMEOUTS = 5;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TIMEOUT_MOTOR,
    REG_TIMEOUT_ADC,
    REG_TIMEOUT_COMMS,
    REG_TIMEOUT_RADIO,
    REG_TIMEOUT_WDT_TASK,
    REG_TIMEOUT_DEFAULT,
    REG_BATT_CRIT,
    REG_BATT_LOW
  } reg_idx_t;

  localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
    16'd10, 16'd25, 16'd50, 16'd100, 16'd200, 16'd100, 16'd3000, 16'd3400
  };

  typedef enum logic [1:0] {
    ACT_HEARTBEAT = 2'd0,
    ACT_SEED      = 2'd1,
    ACT_CHECK     = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    BATT_OK       = 2'd0,
    BATT_LOW      = 2'd1,
    BATT_CRITICAL = 2'd2
  } batt_status_t;

  typedef struct packed {
    action_t           action;
    logic [2:0]        channel;
    logic [TICK_W-1:0] now_ticks;
    logic [MV_W-1:0]   supply_mv;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0] hung_mask;
    batt_status_t      battery_status;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic hb_write;
    logic seed_write;
    logic scan_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    scan_last;
    logic    out_busy;
  } dp_status_t;

  // mask bits a check may ever set
  function automatic logic [MASK_W-1:0] check_mask_f();
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (i < NUM_CHANNELS) && (i != SELF_CHANNEL);
    end
    return m;
  endfunction

  localparam logic [MASK_W-1:0] CHECK_MASK = check_mask_f();

endpackage

// File: hdl/mchb_ctrl.sv
// sequencing state machine of the heartbeat monitor
// depends on mchb_pkg
module mchb_ctrl import mchb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  dp_status_t status,
  output logic       item_ready,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && status.action == ACT_CHECK) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready     = (state == ST_IDLE);
    cmd.capture    = (state == ST_IDLE) && item_valid;
    cmd.hb_write   = cmd.capture && (status.action == ACT_HEARTBEAT);
    cmd.seed_write = cmd.capture && (status.action == ACT_SEED);
    cmd.scan_step  = (state == ST_SCAN);
    cmd.emit       = (state == ST_EMIT) && !status.out_busy;
  end

endmodule

// File: hdl/mchb_datapath.sv
// stamp store, config registers, serial check and result register
// depends on mchb_pkg
module mchb_datapath import mchb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  item_t                item,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result
);

  logic [CFG_W-1:0]  regs [NUM_REGS];
  logic [TICK_W-1:0] stamps [NUM_CHANNELS];
  logic [TICK_W-1:0] now_q;
  logic [MV_W-1:0]   batt_q;
  logic [CH_W-1:0]   idx;
  logic [MASK_W-1:0] mask;

  logic [31:0]       idx_ext;
  logic [CFG_W-1:0]  tmo;
  logic [TICK_W-1:0] since;
  logic              hit;
  logic              hb_in_range;
  batt_status_t      batt_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= REG_RESET[i];
      end
    end else if (wr_en) begin
      regs[wr_index] <= wr_data;
    end
  end

  assign hb_in_range = (32'(item.channel) < 32'(NUM_CHANNELS));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        stamps[i] <= '0;
      end
    end else if (cmd.seed_write) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        stamps[i] <= item.now_ticks;
      end
    end else if (cmd.hb_write && hb_in_range) begin
      stamps[CH_W'(item.channel)] <= item.now_ticks;
    end
  end

  // one channel per cycle
  assign idx_ext = 32'(idx);
  assign tmo     = (idx_ext < 32'(NUM_OWN_TIMEOUTS)) ? regs[REG_IDX_W'(idx)]
                                                     : regs[REG_TIMEOUT_DEFAULT];
  assign since   = now_q - stamps[idx];
  assign hit     = (idx_ext != 32'(SELF_CHANNEL)) && (idx_ext < 32'(MASK_W))
                   && (since > TICK_W'(tmo));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_q  <= item.now_ticks;
      batt_q <= item.supply_mv;
      idx    <= '0;
      mask   <= '0;
    end else if (cmd.scan_step) begin
      idx  <= idx + CH_W'(1);
      mask <= mask | (hit ? (MASK_W'(1) << idx) : '0);
    end
  end

  always_comb begin
    priority if (batt_q < regs[REG_BATT_CRIT]) begin
      batt_st = BATT_CRITICAL;
    end else if (batt_q < regs[REG_BATT_LOW]) begin
      batt_st = BATT_LOW;
    end else begin
      batt_st = BATT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.hung_mask      <= mask;
      result.battery_status <= batt_st;
    end
  end

  assign status.action    = item.action;
  assign status.scan_last = (idx_ext == 32'(NUM_CHANNELS - 1));
  assign status.out_busy  = result_valid && !result_ready;

endmodule

// File: hdl/multi_channel_heartbeat_monitor.sv
// top level of the heartbeat monitor: controller plus datapath
// depends on mchb_pkg, mchb_ctrl, mchb_datapath and the assertion macro header
//
// Keeps one 32-bit tick stamp per channel. A heartbeat or seed beat is written
// into the stamps on acceptance and gives no result. A check beat walks the
// stamps one channel per cycle through a single subtract-and-compare, then its
// result is loaded into the output register and the controller returns to
// idle, where the next beat can be taken; no new beat is taken while a check
// runs, and a check whose result finds the output register still full waits
// until that result is taken. The result register lets the next beat in while
// a result waits to be taken. Configuration writes take effect at the next
// edge; stamps are cleared by reset directly, with no clearing pass.
`include "multi_channel_heartbeat_monitor_macros.svh"

module multi_channel_heartbeat_monitor import mchb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mchb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .status     (status),
    .item_ready (item_ready),
    .cmd        (cmd)
  );

  mchb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // a result never overwrites one still waiting
  `MCHB_ASSERT_IMP(a_emit_slot_free, cmd.emit, !result_valid || result_ready)
  // an emitted result shows up on the port
  `MCHB_ASSERT_NEXT(a_emit_visible, cmd.emit, result_valid)
  // self channel and missing channels never flagged
  `MCHB_ASSERT_IMP(a_mask_legal, result_valid, (result.hung_mask & ~CHECK_MASK) == '0)
  // no beat taken during a scan
  `MCHB_ASSERT_IMP(a_no_accept_in_scan, cmd.scan_step, !item_ready)

endmodule
